// ----- src/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 transcoder: widths, lead byte classes,
// the decoder-to-emitter struct and the surrogate helpers.
// No dependencies.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  localparam logic [CP_W-1:0]   BMP_MAX    = 21'h00FFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h010000;
  localparam logic [UNIT_W-1:0] HI_SURR    = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR    = 16'hDC00;

  // Class of a byte seen with no following bytes pending
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // One finished code point handed from decoder to emitter
  typedef struct packed {
    logic            valid;
    logic [CP_W-1:0] cp;
    logic            eos;
  } emit_t;

  function automatic lead_kind_t classify_lead(input logic [BYTE_W-1:0] b);
    lead_kind_t k;
    unique case (b) inside
      8'b0???????: k = LEAD_ASCII;
      8'b110?????: k = LEAD_TWO;
      8'b1110????: k = LEAD_THREE;
      8'b11110???: k = LEAD_FOUR;
      default:     k = LEAD_BAD;
    endcase
    return k;
  endfunction

  // High surrogate; offset is not masked, so values above 0x10FFFF spill past 0xDBFF
  function automatic logic [UNIT_W-1:0] hi_unit(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] v;
    v = cp - SUPP_BASE;
    return HI_SURR | {5'd0, v[CP_W-1:10]};
  endfunction

  function automatic logic [UNIT_W-1:0] lo_unit(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] v;
    v = cp - SUPP_BASE;
    return LO_SURR | {6'd0, v[9:0]};
  endfunction

endpackage

`default_nettype wire

// ----- src/u8u16_if.sv -----
// Handshake interfaces for the byte input and code unit output channels.
// Depends on u8u16_pkg.
`default_nettype none

interface u8u16_in_if
  import u8u16_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              run_last;
  logic              end_of_string;

  modport source (output valid, output code_unit, output run_last,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input run_last,
                  input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- src/u8u16_decoder.sv -----
// Byte decoder: holds the pending count and partial code point, and flags
// each finished or cut-off code point. Depends on u8u16_pkg.
`default_nettype none

module u8u16_decoder
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              string_end,
  output emit_t                  emit
);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [CP_W-1:0]   acc_r, acc_nxt;
  logic [PEND_W-1:0] pend_step;
  logic [CP_W-1:0]   acc_step;
  logic              complete;
  logic              bad;
  lead_kind_t        kind;

  assign kind = classify_lead(in_byte);

  // Lead byte or continuation byte
  always_comb begin
    pend_step = pend_r;
    acc_step  = acc_r;
    complete  = 1'b0;
    bad       = 1'b0;
    if (pend_r == '0) begin
      unique case (kind)
        LEAD_ASCII: begin
          acc_step = {13'd0, in_byte};
          complete = 1'b1;
        end
        LEAD_TWO: begin
          acc_step  = {16'd0, in_byte[4:0]};
          pend_step = 2'd1;
        end
        LEAD_THREE: begin
          acc_step  = {17'd0, in_byte[3:0]};
          pend_step = 2'd2;
        end
        LEAD_FOUR: begin
          acc_step  = {18'd0, in_byte[2:0]};
          pend_step = 2'd3;
        end
        default: bad = 1'b1;
      endcase
    end else begin
      acc_step  = {acc_r[CP_W-7:0], in_byte[5:0]};
      pend_step = pend_r - 2'd1;
      complete  = (pend_r == 2'd1);
    end
  end

  // State update and emit request
  always_comb begin
    pend_nxt   = pend_r;
    acc_nxt    = acc_r;
    emit.valid = 1'b0;
    emit.cp    = acc_step;
    emit.eos   = string_end;
    if (accept) begin
      if (bad) begin
        if (string_end) begin
          pend_nxt = '0;
          acc_nxt  = '0;
        end
      end else if (complete || string_end) begin
        emit.valid = 1'b1;
        pend_nxt   = '0;
        acc_nxt    = '0;
      end else begin
        pend_nxt = pend_step;
        acc_nxt  = acc_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      acc_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/u8u16_emitter.sv -----
// Output stage: result register plus a holding register for the low
// surrogate word of a pair. Depends on u8u16_pkg.
`default_nettype none

module u8u16_emitter
  import u8u16_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  emit_t                  emit,
  output logic                   take_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [UNIT_W-1:0]      out_code_unit,
  output logic                   out_run_last,
  output logic                   out_end_of_string
);

  logic              ov_r, ov_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic              last_r, last_nxt;
  logic              eos_r, eos_nxt;
  logic              lov_r, lov_nxt;
  logic [UNIT_W-1:0] lo_r, lo_nxt;
  logic              loeos_r, loeos_nxt;
  logic              slot_free;
  logic              pair;

  assign slot_free = !ov_r || out_ready;
  assign take_ok   = slot_free && !lov_r;
  assign pair      = emit.cp > BMP_MAX;

  // Result register loads the held low word first, else a new code point
  always_comb begin
    ov_nxt    = ov_r;
    unit_nxt  = unit_r;
    last_nxt  = last_r;
    eos_nxt   = eos_r;
    lov_nxt   = lov_r;
    lo_nxt    = lo_r;
    loeos_nxt = loeos_r;
    if (slot_free) begin
      if (lov_r) begin
        ov_nxt   = 1'b1;
        unit_nxt = lo_r;
        last_nxt = 1'b1;
        eos_nxt  = loeos_r;
        lov_nxt  = 1'b0;
      end else if (emit.valid) begin
        ov_nxt = 1'b1;
        if (pair) begin
          unit_nxt  = hi_unit(emit.cp);
          last_nxt  = 1'b0;
          eos_nxt   = 1'b0;
          lov_nxt   = 1'b1;
          lo_nxt    = lo_unit(emit.cp);
          loeos_nxt = emit.eos;
        end else begin
          unit_nxt = emit.cp[UNIT_W-1:0];
          last_nxt = 1'b1;
          eos_nxt  = emit.eos;
        end
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      lov_r <= 1'b0;
    end else begin
      ov_r  <= ov_nxt;
      lov_r <= lov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r  <= unit_nxt;
    last_r  <= last_nxt;
    eos_r   <= eos_nxt;
    lo_r    <= lo_nxt;
    loeos_r <= loeos_nxt;
  end

  assign out_valid         = ov_r;
  assign out_code_unit     = unit_r;
  assign out_run_last      = last_r;
  assign out_end_of_string = eos_r;

endmodule

`default_nettype wire

// ----- src/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder, one byte per word in, one code unit per word out.
//
// in_ch carries in_byte and string_end; out_ch carries code_unit, run_last and
// end_of_string. Both use valid/ready; a word moves when both are high.
// A byte that finishes a code point shows its first code unit on out_ch in
// the cycle after it is accepted. Throughput: one byte per cycle, except
// while a low surrogate is held or out_ch stalls. A code point above 0xFFFF
// gives two words; the low surrogate waits in a holding register, and
// in_ch.ready stays low until it is moved into the result register.
// Lead and continuation bytes that finish nothing give no output word.
// Invalid lead bytes are dropped. A string_end mid-sequence flushes the
// partial code point as it stands.
// When out_ch stalls, the result register holds and in_ch.ready falls, since
// in_ch.ready depends on out_ch.ready combinationally.
// Reset (rst_n low, synchronous) clears the pending count, the partial code
// point and both valid flags; the block is ready for a byte as soon as
// reset is released.
// Depends on u8u16_pkg, u8u16_if, u8u16_decoder and u8u16_emitter.
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8u16_in_if.sink   in_ch,
  u8u16_out_if.source out_ch
);

  emit_t emit;
  logic  take_ok;
  logic  accept;

  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  u8u16_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_ch.in_byte),
    .string_end (in_ch.string_end),
    .emit       (emit)
  );

  u8u16_emitter u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .take_ok           (take_ok),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_code_unit     (out_ch.code_unit),
    .out_run_last      (out_ch.run_last),
    .out_end_of_string (out_ch.end_of_string)
  );

endmodule

`default_nettype wire

// ----- src/u8u16_checker.sv -----
// Port-level checks for the transcoder and the bind that attaches them.
// Depends on u8u16_pkg and utf8_to_utf16_transcoder.
`default_nettype none

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [UNIT_W-1:0] code_unit,
  input wire logic              run_last,
  input wire logic              end_of_string
);

  // Output register comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled word holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_unit))
    else $error("stalled code unit changed");

  // While a high surrogate is shown, the low one is held and input is blocked
  a_pair_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> !in_ready)
    else $error("input accepted during surrogate pair");

  // A taken high surrogate is followed at once by a low surrogate
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_last |=>
      out_valid && run_last && (code_unit[15:10] == 6'b110111))
    else $error("low surrogate missing after high surrogate");

  // String close only on the last word of a code point
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_string |-> run_last)
    else $error("end_of_string without run_last");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .code_unit     (out_ch.code_unit),
  .run_last      (out_ch.run_last),
  .end_of_string (out_ch.end_of_string)
);

`default_nettype wire

// ----- tb/sv/tb_utf8_to_utf16_transcoder.sv -----
// Self-checking testbench for utf8_to_utf16_transcoder: a directed byte table, then random
// UTF-8 sequences, each checked word by word against typed expectations or a behavioral decoder.
// Depends on u8u16_pkg, u8u16_if and the transcoder RTL.
`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder
  import u8u16_pkg::*;
  ;

  localparam int RANDOM_ITEMS = 1250;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_N        = 26;

  // One UTF-16 word as seen on the result channel
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              run_last;
    logic              end_of_string;
  } unit_t;

  // One input byte; typed rows carry their expected words, the rest use the decoder
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              fin;
    logic              typed;
    logic [1:0]        n;
    unit_t             w0;
    unit_t             w1;
  } stim_t;

  localparam unit_t NO_WORD = '0;

  localparam stim_t DIRECTED [DIR_N] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, '{16'h0000, 1'b1, 1'b0}, NO_WORD},  // lowest byte
    '{8'h7F, 1'b1, 1'b1, 2'd1, '{16'h007F, 1'b1, 1'b1}, NO_WORD},  // top ASCII, ends string
    '{8'h80, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},                  // stray continuation
    '{8'hBF, 1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},                  // bad lead with end
    '{8'hF8, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},                  // bad lead
    '{8'hDF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // two-byte max
    '{8'hBF, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hE2, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // three-byte
    '{8'h82, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hAC, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hEF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // BMP max
    '{8'hBF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hBF, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hF0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // surrogate pair
    '{8'h9F, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'h98, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'h80, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hF7, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // beyond 0x10FFFF
    '{8'hBF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hBF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hBF, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hE2, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // early end, partial cp
    '{8'h82, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hC3, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},                  // follower not 10xxxxxx
    '{8'h41, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hF4, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD}                   // end right on a lead
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_transcoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state and the words still owed by the block
  logic [PEND_W-1:0] dec_pending = '0;
  logic [CP_W-1:0]   dec_cp      = '0;
  unit_t             unit_q [$];
  stim_t             byte_q [$];
  stim_t             cur_item    = '0;
  int                err_count   = 0;
  int                cycles      = 0;
  logic              in_gaps_on  = 1'b1;
  logic              out_stall_on = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    err_count++;
  endtask

  // Append to the tail of the stimulus and expectation queues
  function automatic void queue_byte(input stim_t s);
    byte_q.insert(byte_q.size(), s);
  endfunction

  function automatic void queue_word(input unit_t w);
    unit_q.insert(unit_q.size(), w);
  endfunction

  // Behavioral decoder: consumes one byte, returns how many words it yields
  function automatic int decode_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                     output unit_t w0, output unit_t w1);
    lead_kind_t      kind;
    logic            done;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] off;
    done = 1'b0;
    w0   = NO_WORD;
    w1   = NO_WORD;
    if (dec_pending == 0) begin
      if (!b[7])                kind = LEAD_ASCII;
      else if (b[7:5] == 3'b110) kind = LEAD_TWO;
      else if (b[7:4] == 4'b1110) kind = LEAD_THREE;
      else if (b[7:3] == 5'b11110) kind = LEAD_FOUR;
      else                      kind = LEAD_BAD;
      case (kind)
        LEAD_ASCII: begin
          dec_cp = {13'd0, b};
          done   = 1'b1;
        end
        LEAD_TWO: begin
          dec_cp      = {16'd0, b[4:0]};
          dec_pending = 2'd1;
        end
        LEAD_THREE: begin
          dec_cp      = {17'd0, b[3:0]};
          dec_pending = 2'd2;
        end
        LEAD_FOUR: begin
          dec_cp      = {18'd0, b[2:0]};
          dec_pending = 2'd3;
        end
        default: begin
          // dropped byte; an end flag still closes the string
          if (fin) begin
            dec_pending = '0;
            dec_cp      = '0;
          end
          return 0;
        end
      endcase
    end else begin
      dec_cp      = {dec_cp[CP_W-7:0], b[5:0]};
      dec_pending = dec_pending - 1'b1;
      done        = (dec_pending == 0);
    end
    if (!(done || fin)) return 0;
    cp          = dec_cp;
    dec_pending = '0;
    dec_cp      = '0;
    if (cp <= BMP_MAX) begin
      w0 = '{cp[UNIT_W-1:0], 1'b1, fin};
      return 1;
    end
    // high half keeps all upper offset bits, no mask
    off = cp - SUPP_BASE;
    w0  = '{HI_SURR | {5'd0, off[CP_W-1:10]}, 1'b0, 1'b0};
    w1  = '{LO_SURR | {6'd0, off[9:0]}, 1'b1, fin};
    return 2;
  endfunction

  function automatic logic [BYTE_W-1:0] lead_byte(input int len);
    logic [31:0] r;
    r = $urandom;
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic stim_t plain_byte(input logic [BYTE_W-1:0] b, input logic fin);
    stim_t s;
    s     = '0;
    s.b   = b;
    s.fin = fin;
    return s;
  endfunction

  // One random burst: mostly well-formed characters, some truncated, broken or noise
  task automatic add_random_seq();
    int          kind;
    int          len;
    int          keep;
    logic [31:0] r;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    if (kind < 7) begin
      queue_byte(plain_byte(lead_byte(len), len == 1 && $urandom_range(0, 7) == 0));
      for (int i = 1; i < len; i++) begin
        r = $urandom;
        queue_byte(plain_byte({2'b10, r[5:0]}, i == len - 1 && r[8:6] == 3'd0));
      end
    end else if (kind == 7) begin
      // string ends before the character is complete
      len  = $urandom_range(2, 4);
      keep = $urandom_range(1, len - 1);
      queue_byte(plain_byte(lead_byte(len), keep == 1));
      for (int i = 1; i < keep; i++) begin
        r = $urandom;
        queue_byte(plain_byte({2'b10, r[5:0]}, i == keep - 1));
      end
    end else if (kind == 8) begin
      // followers of any value
      len = $urandom_range(2, 4);
      queue_byte(plain_byte(lead_byte(len), 1'b0));
      for (int i = 1; i < len; i++) begin
        r = $urandom;
        queue_byte(plain_byte(r[7:0], i == len - 1 && r[9:8] == 2'd0));
      end
    end else begin
      r = $urandom;
      queue_byte(plain_byte(r[7:0], r[9:8] == 2'd0));
    end
  endtask

  // Compare one delivered word with the oldest expectation
  task automatic check_word();
    unit_t exp_w;
    if (unit_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h rl=%b eos=%b", out_ch.code_unit,
                                out_ch.run_last, out_ch.end_of_string));
    end else begin
      exp_w = unit_q.pop_front();
      if (out_ch.code_unit !== exp_w.code_unit || out_ch.run_last !== exp_w.run_last ||
          out_ch.end_of_string !== exp_w.end_of_string)
        report_mismatch($sformatf("got %h rl=%b eos=%b, want %h rl=%b eos=%b",
                                  out_ch.code_unit, out_ch.run_last, out_ch.end_of_string,
                                  exp_w.code_unit, exp_w.run_last, exp_w.end_of_string));
    end
  endtask

  // Record the words an accepted byte should produce
  task automatic take_byte();
    unit_t p0;
    unit_t p1;
    int    n;
    n = decode_byte(in_ch.in_byte, in_ch.string_end, p0, p1);
    if (cur_item.typed) begin
      n  = int'(cur_item.n);
      p0 = cur_item.w0;
      p1 = cur_item.w1;
    end
    if (n > 0) queue_word(p0);
    if (n > 1) queue_word(p1);
  endtask

  // Sample both channels at the rising edge; check before predicting
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (in_ch.valid && in_ch.ready) take_byte();
    end
  end

  // Result side: random stall before each word, with stall-free stretches
  initial begin : sink_side
    int stall;
    int words;
    words        = 0;
    out_ch.ready = 1'b0;
    forever begin
      stall = out_stall_on ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      words++;
      if (words % 64 == 0) out_stall_on = ($urandom_range(0, 3) != 0);
    end
  end

  // Byte side: reset, then the table and the random bytes
  initial begin : source_side
    int gap;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.string_end = 1'b0;
    for (int i = 0; i < DIR_N; i++) queue_byte(DIRECTED[i]);
    while (byte_q.size() < DIR_N + RANDOM_ITEMS) add_random_seq();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < byte_q.size(); i++) begin
      if (i % 64 == 0) in_gaps_on = ($urandom_range(0, 3) != 0);
      gap = in_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_ch.valid      <= 1'b1;
      in_ch.in_byte    <= byte_q[i].b;
      in_ch.string_end <= byte_q[i].fin;
      cur_item         <= byte_q[i];
      do @(posedge clk); while (!in_ch.ready);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (unit_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (unit_q.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", unit_q.size()));
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- utf8_to_utf16_transcoder.f -----
src/u8u16_pkg.sv
src/u8u16_if.sv
src/u8u16_decoder.sv
src/u8u16_emitter.sv
src/utf8_to_utf16_transcoder.sv
src/u8u16_checker.sv
tb/sv/tb_utf8_to_utf16_transcoder.sv
